@@ sv/tck_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and helper functions of the two-cable kinematics unit.
// Used by the top level; depends on nothing else.
package tck_pkg;

  // Default number of fraction bits of the fixed-point values.
  localparam int FRACTION_BITS_DEF = 8;

  // Operating modes carried in the mode field of a request.
  localparam logic [1:0] MODE_FWD = 2'd0;
  localparam logic [1:0] MODE_INV = 2'd1;
  localparam logic [1:0] MODE_VEL = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] CFG_SPAN   = 2'd0;
  localparam logic [1:0] CFG_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_CABLE  = 2'd2;

  // Step counts and widths of the four cell chains.
  localparam int X_STEPS = 32;  // forward lambda divider, quotient bits
  localparam int X_DW    = 16;  // divisor bits (twice the span)
  localparam int P_STEPS = 17;  // first square root, root bits
  localparam int Q_STEPS = 16;  // second square root, root bits
  localparam int Y_STEPS = 33;  // rate divider, quotient bits
  localparam int Y_DW    = 17;  // divisor bits (distances)

  typedef struct packed {
    logic [1:0]         mode;
    logic signed [15:0] first_value;
    logic signed [15:0] second_value;
    logic signed [15:0] speed_x;
    logic signed [15:0] speed_y;
  } item_t;

  typedef struct packed {
    logic signed [15:0] out_first;
    logic signed [15:0] out_second;
    logic               within_limits;
    logic               no_solution;
  } result_t;

  // Sideband that travels with a request along the cell chains.
  typedef struct packed {
    logic [1:0]         mode;
    logic signed [15:0] a;
    logic [30:0]        a2;
    logic               in_window;
    logic               nosol;
    logic [31:0]        sl;
    logic [32:0]        sr;
    logic signed [32:0] nl;
    logic signed [32:0] nr;
    logic [16:0]        dl;
    logic [16:0]        dr;
    logic signed [15:0] res1;
    logic signed [15:0] res2;
    logic               agty;
  } side_t;

  // Reset value of the anchor span for a given scale.
  function automatic logic [14:0] span_reset(input int fb);
    logic [63:0] v;
    v = 64'd105 << (fb - 1);
    return v[14:0];
  endfunction

  // Reset value of the travel height for a given scale.
  function automatic logic [14:0] height_reset(input int fb);
    logic [63:0] v;
    v = 64'd129 << (fb - 1);
    return v[14:0];
  endfunction

  // Reset value of the cable limit: floor root of span^2 + height^2.
  function automatic logic [14:0] cable_reset(input int fb);
    logic [63:0] s;
    logic [63:0] h;
    logic [63:0] v;
    logic [63:0] res;
    logic [63:0] b;
    s = 64'(span_reset(fb));
    h = 64'(height_reset(fb));
    v = s * s + h * h;
    res = 64'd0;
    b = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res[14:0];
  endfunction

  // Clamp an unsigned magnitude to the largest positive output.
  function automatic logic signed [15:0] sat_u(input logic [16:0] v);
    return (v > 17'd32767) ? 16'sh7FFF : $signed(v[15:0]);
  endfunction

  // Apply a sign to a magnitude and clamp to the output range.
  function automatic logic signed [15:0] sat_s(input logic neg, input logic [32:0] m);
    logic signed [15:0] r;
    if (neg) begin
      r = (m > 33'd32768) ? 16'sh8000 : $signed(16'd0 - m[15:0]);
    end else begin
      r = (m > 33'd32767) ? 16'sh7FFF : $signed(m[15:0]);
    end
    return r;
  endfunction

endpackage

@@ sv/tck_sqrt_cell.sv @@
`timescale 1ns / 1ps
// One step of a digit-by-digit integer square root, for one or more lanes.
// Chained K deep it yields the floor root; uses no package items.
module tck_sqrt_cell #(
  parameter int K     = 17,
  parameter int LANES = 1,
  parameter int PW    = 1
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            en,
  input  logic                            vld,
  input  logic [LANES-1:0][2*K-1:0]       rad,
  input  logic [LANES-1:0][K+1:0]         rem,
  input  logic [LANES-1:0][K-1:0]         root,
  input  logic [PW-1:0]                   pass,
  output logic                            vld_r,
  output logic [LANES-1:0][2*K-1:0]       rad_r,
  output logic [LANES-1:0][K+1:0]         rem_r,
  output logic [LANES-1:0][K-1:0]         root_r,
  output logic [PW-1:0]                   pass_r
);

  logic [LANES-1:0][2*K-1:0] rad_next;
  logic [LANES-1:0][K+1:0]   rem_next;
  logic [LANES-1:0][K-1:0]   root_next;

  // Each lane brings down two radicand bits and tries the next root bit.
  for (genvar l = 0; l < LANES; l++) begin : g_lane
    logic [K+3:0] t;
    logic [K+3:0] trial;
    logic [K+3:0] diff;
    logic         ge;
    assign t     = {rem[l], rad[l][2*K-1 -: 2]};
    assign trial = {2'b00, root[l], 2'b01};
    assign diff  = t - trial;
    assign ge    = (t >= trial);
    assign rem_next[l]  = ge ? diff[K+1:0] : t[K+1:0];
    assign root_next[l] = {root[l][K-2:0], ge};
    assign rad_next[l]  = {rad[l][2*K-3:0], 2'b00};
  end

  // The valid bit is control state and is cleared by reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld;
    end
  end

  // Working values move on to the next cell.
  always_ff @(posedge clk) begin
    if (en) begin
      rad_r  <= rad_next;
      rem_r  <= rem_next;
      root_r <= root_next;
      pass_r <= pass;
    end
  end

endmodule

@@ sv/tck_div_cell.sv @@
`timescale 1ns / 1ps
// One step of a restoring unsigned divider, for one or more lanes.
// Chained N deep it yields the N-bit quotient; uses no package items.
module tck_div_cell #(
  parameter int N     = 32,
  parameter int DW    = 16,
  parameter int LANES = 1,
  parameter int PW    = 1
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      vld,
  input  logic [LANES-1:0][N-1:0]   dq,
  input  logic [LANES-1:0][DW-1:0]  rem,
  input  logic [LANES-1:0][DW-1:0]  d,
  input  logic [PW-1:0]             pass,
  output logic                      vld_r,
  output logic [LANES-1:0][N-1:0]   dq_r,
  output logic [LANES-1:0][DW-1:0]  rem_r,
  output logic [LANES-1:0][DW-1:0]  d_r,
  output logic [PW-1:0]             pass_r
);

  logic [LANES-1:0][N-1:0]  dq_next;
  logic [LANES-1:0][DW-1:0] rem_next;

  // Shift in the next dividend bit and subtract the divisor when it fits.
  // Dividend bits leave at the top of dq while quotient bits enter below.
  for (genvar l = 0; l < LANES; l++) begin : g_lane
    logic [DW:0] t;
    logic [DW:0] dd;
    logic [DW:0] diff;
    logic        ge;
    assign t    = {rem[l], dq[l][N-1]};
    assign dd   = {1'b0, d[l]};
    assign diff = t - dd;
    assign ge   = (t >= dd);
    assign rem_next[l] = ge ? diff[DW-1:0] : t[DW-1:0];
    assign dq_next[l]  = {dq[l][N-2:0], ge};
  end

  // The valid bit is control state and is cleared by reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld;
    end
  end

  // Working values move on to the next cell.
  always_ff @(posedge clk) begin
    if (en) begin
      dq_r   <= dq_next;
      rem_r  <= rem_next;
      d_r    <= d;
      pass_r <= pass;
    end
  end

endmodule

@@ sv/two_cable_kinematics_unit.sv @@
`timescale 1ns / 1ps
// Top level of the two-cable kinematics unit: a pipeline of divider and root cells.
// Depends on tck_pkg, tck_div_cell and tck_sqrt_cell.
//
// Usage:
// - Requests enter on item/item_valid/item_stall and results leave on
//   result/result_valid/result_stall. A request moves at a rising edge where
//   valid is high and stall is low. Each request gives exactly one result.
// - Mode forward turns cable lengths into a pose, mode inverse turns a pose
//   into cable lengths, mode velocity turns a pose and velocity into cable rates.
// - Configuration writes use cfg_valid/cfg_ready/cfg_index/cfg_data; cfg_ready is
//   always high. Write only while no request is in flight.
// - The path from the accepting edge to result_valid runs through two setup
//   stages, a 32-cell lambda divider, two stages, a 17-cell root chain, two
//   stages, a 16-cell root chain, one stage, a 33-cell rate divider and the
//   output stage. Every cell resolves one quotient bit or one root bit.
// - Throughput is one request per cycle while results are taken.
// - When the receiver stalls, the pipeline moves once more into a one-entry skid
//   register, then holds and raises item_stall until that entry drains.
// - Synchronous reset empties the pipeline and the skid register and loads the
//   default span, height and cable limit for the chosen fraction width.
module two_cable_kinematics_unit #(
  parameter int FRACTION_BITS = tck_pkg::FRACTION_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            item_valid,
  output logic            item_stall,
  input  tck_pkg::item_t  item,
  output logic            result_valid,
  input  logic            result_stall,
  output tck_pkg::result_t result,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [1:0]      cfg_index,
  input  logic [14:0]     cfg_data
);

  localparam logic [14:0] SPAN_RST   = tck_pkg::span_reset(FRACTION_BITS);
  localparam logic [14:0] HEIGHT_RST = tck_pkg::height_reset(FRACTION_BITS);
  localparam logic [14:0] CABLE_RST  = tck_pkg::cable_reset(FRACTION_BITS);
  localparam int XN  = tck_pkg::X_STEPS;
  localparam int XDW = tck_pkg::X_DW;
  localparam int PK  = tck_pkg::P_STEPS;
  localparam int QK  = tck_pkg::Q_STEPS;
  localparam int YN  = tck_pkg::Y_STEPS;
  localparam int YDW = tck_pkg::Y_DW;
  localparam int PW  = $bits(tck_pkg::side_t);

  // Configuration registers.
  logic [14:0] anchor_span;
  logic [14:0] travel_height;
  logic [14:0] cable_limit;

  // Pipeline advance and output skid.
  logic             adv;
  logic             skid_full;
  tck_pkg::result_t skid;

  // Setup stage one: products and limit check.
  logic               v1;
  logic [1:0]         mode1;
  logic signed [15:0] a1;
  logic [30:0]        a2_1;
  logic [30:0]        b2_1;
  logic [32:0]        dx2_1;
  logic [29:0]        span2_1;
  logic signed [31:0] pa1;
  logic signed [31:0] pb1;
  logic signed [33:0] pd1;
  logic               within1;
  logic               spanz1;

  logic signed [17:0] dx_c;
  logic signed [31:0] m_aa;
  logic signed [31:0] m_bb;
  logic signed [35:0] m_dd;
  logic signed [31:0] m_pa;
  logic signed [31:0] m_pb;
  logic signed [33:0] m_pd;
  logic               within_c;

  // Setup stage two: sums and the forward dividend.
  logic               v2;
  tck_pkg::side_t     side2;
  logic [XN-1:0]      xdiv2;
  logic [32:0]        num_c;
  logic [32:0]        mag_c;
  tck_pkg::side_t     side2_c;

  // Lambda divider chain.
  logic                     x_vld  [0:XN];
  logic [0:0][XN-1:0]       x_dq   [0:XN];
  logic [0:0][XDW-1:0]      x_rem  [0:XN];
  logic [0:0][XDW-1:0]      x_d    [0:XN];
  logic [PW-1:0]            x_pass [0:XN];

  // Stages three and four: radicand check and first root inputs.
  logic               v3;
  tck_pkg::side_t     side3;
  tck_pkg::side_t     side3_c;
  logic [30:0]        lam2_3;
  tck_pkg::side_t     side_x;
  logic [XN-1:0]      xq;
  logic [16:0]        absa_c;
  logic               bad_c;
  logic [33:0]        lam2_c;
  logic               v4;
  tck_pkg::side_t     side4;
  logic [1:0][2*PK-1:0] prad4;

  // First root chain, two lanes.
  logic                     p_vld  [0:PK];
  logic [1:0][2*PK-1:0]     p_rad  [0:PK];
  logic [1:0][PK+1:0]       p_rem  [0:PK];
  logic [1:0][PK-1:0]       p_root [0:PK];
  logic [PW-1:0]            p_pass [0:PK];

  // Stages five and six: first roots and second root input.
  logic               v5;
  tck_pkg::side_t     side5;
  logic [30:0]        y2_5;
  tck_pkg::side_t     side5_c;
  tck_pkg::side_t     side_p;
  logic [33:0]        y2_c;
  logic               v6;
  tck_pkg::side_t     side6;
  logic [2*QK-1:0]    qrad6;

  // Second root chain.
  logic                     q_vld  [0:QK];
  logic [0:0][2*QK-1:0]     q_rad  [0:QK];
  logic [0:0][QK+1:0]       q_rem  [0:QK];
  logic [0:0][QK-1:0]       q_root [0:QK];
  logic [PW-1:0]            q_pass [0:QK];

  // Stage seven: rate dividends.
  logic               v7;
  tck_pkg::side_t     side7;
  logic [1:0][YN-1:0] ydq7;
  logic [1:0][YDW-1:0] yd7;
  tck_pkg::side_t     side7_c;
  tck_pkg::side_t     side_q;
  logic [YN-1:0]      absl_c;
  logic [YN-1:0]      absr_c;

  // Rate divider chain, two lanes.
  logic                     y_vld  [0:YN];
  logic [1:0][YN-1:0]       y_dq   [0:YN];
  logic [1:0][YDW-1:0]      y_rem  [0:YN];
  logic [1:0][YDW-1:0]      y_d    [0:YN];
  logic [PW-1:0]            y_pass [0:YN];

  // Output stage.
  logic               v8;
  logic [1:0]         mode8;
  tck_pkg::result_t   out8;
  tck_pkg::result_t   out8_c;
  tck_pkg::side_t     side_y;

  assign cfg_ready  = 1'b1;
  assign adv        = !skid_full;
  assign item_stall = skid_full;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      anchor_span   <= SPAN_RST;
      travel_height <= HEIGHT_RST;
      cable_limit   <= CABLE_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        tck_pkg::CFG_SPAN:   anchor_span   <= cfg_data;
        tck_pkg::CFG_HEIGHT: travel_height <= cfg_data;
        tck_pkg::CFG_CABLE:  cable_limit   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Stage one products and the window check of the incoming request.
  assign dx_c = $signed({3'b000, anchor_span}) - 18'(item.first_value);
  assign m_aa = item.first_value * item.first_value;
  assign m_bb = item.second_value * item.second_value;
  assign m_dd = 36'(dx_c) * 36'(dx_c);
  assign m_pa = item.speed_x * item.first_value;
  assign m_pb = item.speed_y * item.second_value;
  assign m_pd = 34'(dx_c) * 34'(item.speed_x);

  always_comb begin
    within_c = 1'b0;
    if (item.mode == tck_pkg::MODE_FWD) begin
      within_c = (item.first_value >= 16'sd0) &&
                 (item.first_value <= $signed({1'b0, cable_limit})) &&
                 (item.second_value >= 16'sd0) &&
                 (item.second_value <= $signed({1'b0, cable_limit}));
    end else if (item.mode == tck_pkg::MODE_INV || item.mode == tck_pkg::MODE_VEL) begin
      within_c = (item.first_value >= 16'sd0) &&
                 (item.first_value <= $signed({1'b0, anchor_span})) &&
                 (item.second_value >= 16'sd0) &&
                 (item.second_value <= $signed({1'b0, travel_height}));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mode1   <= item.mode;
      a1      <= item.first_value;
      a2_1    <= m_aa[30:0];
      b2_1    <= m_bb[30:0];
      dx2_1   <= m_dd[32:0];
      span2_1 <= 30'(anchor_span) * 30'(anchor_span);
      pa1     <= m_pa;
      pb1     <= m_pb;
      pd1     <= m_pd;
      within1 <= within_c;
      spanz1  <= (anchor_span == 15'd0);
    end
  end

  // Stage two: forward numerator with rounding offset, distance and rate sums.
  assign num_c = 33'(span2_1) + 33'(a2_1) - 33'(b2_1);
  assign mag_c = num_c[32] ? (33'd0 - num_c) : num_c;

  always_comb begin
    side2_c           = '0;
    side2_c.mode      = mode1;
    side2_c.a         = a1;
    side2_c.a2        = a2_1;
    side2_c.in_window = within1;
    side2_c.nosol     = (mode1 == tck_pkg::MODE_FWD) && spanz1;
    side2_c.sl        = 32'(a2_1) + 32'(b2_1);
    side2_c.sr        = dx2_1 + 33'(b2_1);
    side2_c.nl        = 33'(pa1) + 33'(pb1);
    side2_c.nr        = 33'(pb1) - pd1[32:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side2 <= side2_c;
      xdiv2 <= mag_c[XN-1:0] + XN'(anchor_span);
    end
  end

  // Lambda divider: one quotient bit per cell, divisor is twice the span.
  assign x_vld[0]  = v2;
  assign x_dq[0]   = xdiv2;
  assign x_rem[0]  = '0;
  assign x_d[0]    = {anchor_span, 1'b0};
  assign x_pass[0] = side2;

  for (genvar i = 0; i < XN; i++) begin : g_x
    tck_div_cell #(.N(XN), .DW(XDW), .LANES(1), .PW(PW)) u_cell (
      .clk    (clk),
      .rst    (rst),
      .en     (adv),
      .vld    (x_vld[i]),
      .dq     (x_dq[i]),
      .rem    (x_rem[i]),
      .d      (x_d[i]),
      .pass   (x_pass[i]),
      .vld_r  (x_vld[i+1]),
      .dq_r   (x_dq[i+1]),
      .rem_r  (x_rem[i+1]),
      .d_r    (x_d[i+1]),
      .pass_r (x_pass[i+1])
    );
  end

  // Stage three: the radicand is negative exactly when |lambda| exceeds |a|.
  assign side_x = tck_pkg::side_t'(x_pass[XN]);
  assign xq     = x_dq[XN][0];
  assign absa_c = side_x.a[15] ? (17'd0 - {side_x.a[15], side_x.a}) : {1'b0, side_x.a};
  assign bad_c  = (xq > XN'(absa_c));
  assign lam2_c = 34'(xq[16:0]) * 34'(xq[16:0]);

  always_comb begin
    side3_c       = side_x;
    side3_c.nosol = side_x.nosol || ((side_x.mode == tck_pkg::MODE_FWD) && bad_c);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (adv) begin
      v3 <= x_vld[XN];
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side3  <= side3_c;
      lam2_3 <= lam2_c[30:0];
    end
  end

  // Stage four: pick the radicands of the first root chain.
  always_ff @(posedge clk) begin
    if (adv) begin
      side4    <= side3;
      prad4[0] <= (side3.mode == tck_pkg::MODE_FWD) ?
                  (2*PK)'(side3.a2 - lam2_3) : (2*PK)'(side3.sl);
      prad4[1] <= (2*PK)'(side3.sr);
    end
  end

  // First root chain: y in forward mode, both distances otherwise.
  assign p_vld[0]  = v4;
  assign p_rad[0]  = prad4;
  assign p_rem[0]  = '0;
  assign p_root[0] = '0;
  assign p_pass[0] = side4;

  for (genvar i = 0; i < PK; i++) begin : g_p
    tck_sqrt_cell #(.K(PK), .LANES(2), .PW(PW)) u_cell (
      .clk    (clk),
      .rst    (rst),
      .en     (adv),
      .vld    (p_vld[i]),
      .rad    (p_rad[i]),
      .rem    (p_rem[i]),
      .root   (p_root[i]),
      .pass   (p_pass[i]),
      .vld_r  (p_vld[i+1]),
      .rad_r  (p_rad[i+1]),
      .rem_r  (p_rem[i+1]),
      .root_r (p_root[i+1]),
      .pass_r (p_pass[i+1])
    );
  end

  // Stage five: record roots and set up the second root in forward mode.
  assign side_p = tck_pkg::side_t'(p_pass[PK]);
  assign y2_c   = 34'(p_root[PK][0]) * 34'(p_root[PK][0]);

  always_comb begin
    side5_c      = side_p;
    side5_c.dl   = p_root[PK][0];
    side5_c.dr   = p_root[PK][1];
    side5_c.agty = 1'b0;
    if (side_p.mode == tck_pkg::MODE_FWD) begin
      side5_c.res2 = tck_pkg::sat_u(p_root[PK][0]);
      side5_c.agty = ($signed(side_p.a) > $signed({1'b0, p_root[PK][0]}));
    end else if (side_p.mode == tck_pkg::MODE_INV) begin
      side5_c.res1 = tck_pkg::sat_u(p_root[PK][0]);
      side5_c.res2 = tck_pkg::sat_u(p_root[PK][1]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
      v6 <= 1'b0;
    end else if (adv) begin
      v5 <= p_vld[PK];
      v6 <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side5 <= side5_c;
      y2_5  <= y2_c[30:0];
    end
  end

  // Stage six: radicand a^2 - y^2 when a exceeds y, else zero.
  always_ff @(posedge clk) begin
    if (adv) begin
      side6 <= side5;
      qrad6 <= side5.agty ? (2*QK)'(side5.a2 - y2_5) : '0;
    end
  end

  // Second root chain: x in forward mode.
  assign q_vld[0]  = v6;
  assign q_rad[0]  = qrad6;
  assign q_rem[0]  = '0;
  assign q_root[0] = '0;
  assign q_pass[0] = side6;

  for (genvar i = 0; i < QK; i++) begin : g_q
    tck_sqrt_cell #(.K(QK), .LANES(1), .PW(PW)) u_cell (
      .clk    (clk),
      .rst    (rst),
      .en     (adv),
      .vld    (q_vld[i]),
      .rad    (q_rad[i]),
      .rem    (q_rem[i]),
      .root   (q_root[i]),
      .pass   (q_pass[i]),
      .vld_r  (q_vld[i+1]),
      .rad_r  (q_rad[i+1]),
      .rem_r  (q_rem[i+1]),
      .root_r (q_root[i+1]),
      .pass_r (q_pass[i+1])
    );
  end

  // Stage seven: x result and the rounded rate dividends.
  assign side_q = tck_pkg::side_t'(q_pass[QK]);
  assign absl_c = side_q.nl[32] ? (YN'(0) - side_q.nl) : side_q.nl;
  assign absr_c = side_q.nr[32] ? (YN'(0) - side_q.nr) : side_q.nr;

  always_comb begin
    side7_c = side_q;
    if (side_q.mode == tck_pkg::MODE_FWD) begin
      side7_c.res1 = $signed(q_root[QK][0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v7 <= 1'b0;
    end else if (adv) begin
      v7 <= q_vld[QK];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side7   <= side7_c;
      ydq7[0] <= absl_c + YN'(side_q.dl >> 1);
      ydq7[1] <= absr_c + YN'(side_q.dr >> 1);
      yd7[0]  <= side_q.dl;
      yd7[1]  <= side_q.dr;
    end
  end

  // Rate divider: both lanes divide by their own distance.
  assign y_vld[0]  = v7;
  assign y_dq[0]   = ydq7;
  assign y_rem[0]  = '0;
  assign y_d[0]    = yd7;
  assign y_pass[0] = side7;

  for (genvar i = 0; i < YN; i++) begin : g_y
    tck_div_cell #(.N(YN), .DW(YDW), .LANES(2), .PW(PW)) u_cell (
      .clk    (clk),
      .rst    (rst),
      .en     (adv),
      .vld    (y_vld[i]),
      .dq     (y_dq[i]),
      .rem    (y_rem[i]),
      .d      (y_d[i]),
      .pass   (y_pass[i]),
      .vld_r  (y_vld[i+1]),
      .dq_r   (y_dq[i+1]),
      .rem_r  (y_rem[i+1]),
      .d_r    (y_d[i+1]),
      .pass_r (y_pass[i+1])
    );
  end

  // Output stage: choose the result fields by mode.
  assign side_y = tck_pkg::side_t'(y_pass[YN]);

  always_comb begin
    out8_c = '0;
    unique case (side_y.mode)
      tck_pkg::MODE_FWD: begin
        out8_c.within_limits = side_y.in_window;
        out8_c.no_solution   = side_y.nosol;
        out8_c.out_first     = side_y.nosol ? 16'sd0 : side_y.res1;
        out8_c.out_second    = side_y.nosol ? 16'sd0 : side_y.res2;
      end
      tck_pkg::MODE_INV: begin
        out8_c.within_limits = side_y.in_window;
        out8_c.out_first     = side_y.res1;
        out8_c.out_second    = side_y.res2;
      end
      tck_pkg::MODE_VEL: begin
        out8_c.within_limits = side_y.in_window;
        out8_c.no_solution   = (side_y.dl == 17'd0) || (side_y.dr == 17'd0);
        out8_c.out_first     = (side_y.dl == 17'd0) ? 16'sd0 :
                               tck_pkg::sat_s(side_y.nl[32], y_dq[YN][0]);
        out8_c.out_second    = (side_y.dr == 17'd0) ? 16'sd0 :
                               tck_pkg::sat_s(side_y.nr[32], y_dq[YN][1]);
      end
      default: out8_c = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v8 <= 1'b0;
    end else if (adv) begin
      v8 <= y_vld[YN];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out8  <= out8_c;
      mode8 <= side_y.mode;
    end
  end

  // Skid register catches the last stage when the receiver stalls.
  always_ff @(posedge clk) begin
    if (rst) begin
      skid_full <= 1'b0;
    end else if (skid_full) begin
      if (!result_stall) begin
        skid_full <= 1'b0;
      end
    end else if (v8 && result_stall) begin
      skid_full <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_full && v8 && result_stall) begin
      skid <= out8;
    end
  end

  assign result_valid = skid_full || v8;
  assign result       = skid_full ? skid : out8;

  // Assertions.
  a_stall_has_result: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> result_valid)
    else $error("input stalled while no result is offered");

  a_skid_on_stall: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_full) |-> $past(result_stall))
    else $error("skid register filled without a receiver stall");

  a_fwd_zero: assert property (@(posedge clk) disable iff (rst)
    (v8 && mode8 == tck_pkg::MODE_FWD && out8.no_solution) |->
    (out8.out_first == 16'sd0 && out8.out_second == 16'sd0))
    else $error("forward result without solution is not zero");

endmodule
